FILE: hw/rtl/vad_pkg.sv
`timescale 1ns / 1ps
package vad_pkg;

  localparam logic [5:0] FmtU8x4   = 6'd6;
  localparam logic [5:0] FmtU16x2  = 6'd25;
  localparam logic [5:0] FmtU16x4  = 6'd26;
  localparam logic [5:0] FmtHalfx2 = 6'd31;
  localparam logic [5:0] FmtHalfx4 = 6'd32;
  localparam logic [5:0] FmtF32x1a = 6'd33;
  localparam logic [5:0] FmtF32x2a = 6'd34;
  localparam logic [5:0] FmtF32x4a = 6'd35;
  localparam logic [5:0] FmtF32x1b = 6'd36;
  localparam logic [5:0] FmtF32x2b = 6'd37;
  localparam logic [5:0] FmtF32x4b = 6'd38;
  localparam logic [5:0] FmtF32x3  = 6'd57;

  localparam logic [1:0] EndNone   = 2'd0;
  localparam logic [1:0] EndSwap16 = 2'd1;
  localparam logic [1:0] EndSwap32 = 2'd2;
  localparam logic [1:0] EndHalves = 2'd3;

  localparam logic [31:0] OneBits = 32'h3F80_0000;

  typedef enum logic [1:0] {
    LaneRaw,
    LaneHalf,
    LaneInt
  } lane_kind_e;

  typedef struct packed {
    lane_kind_e  kind;
    logic [31:0] raw;
    logic        sgn;
    logic        nrm;
    logic        wide;
  } lane_t;

endpackage

FILE: hw/rtl/vad_in_if.sv
`timescale 1ns / 1ps
interface vad_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_lo;
  logic [63:0] data_hi;
  logic [5:0]  format_code;
  logic [1:0]  endian_mode;
  logic        twos_comp;
  logic        unit_norm;

  modport source (
    output valid, data_lo, data_hi, format_code, endian_mode, twos_comp, unit_norm,
    input  ready
  );
  modport sink (
    input  valid, data_lo, data_hi, format_code, endian_mode, twos_comp, unit_norm,
    output ready
  );
endinterface

FILE: hw/rtl/vad_out_if.sv
`timescale 1ns / 1ps
interface vad_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] comp_x;
  logic [31:0] comp_y;
  logic [31:0] comp_z;
  logic [31:0] comp_w;

  modport source (
    output valid, comp_x, comp_y, comp_z, comp_w,
    input  ready
  );
  modport sink (
    input  valid, comp_x, comp_y, comp_z, comp_w,
    output ready
  );
endinterface

FILE: hw/rtl/vad_unpack.sv
`timescale 1ns / 1ps
module vad_unpack import vad_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [63:0]       data_lo_i,
  input  logic [63:0]       data_hi_i,
  input  logic [5:0]        format_code_i,
  input  logic [1:0]        endian_mode_i,
  input  logic              twos_comp_i,
  input  logic              unit_norm_i,
  output lane_t [3:0]       lanes_o
);

  logic [7:0]  byt [16];
  logic [7:0]  sw  [16];
  logic [2:0]  comps;
  logic [2:0]  width;
  logic [5:0]  span;
  logic        do32;
  logic        doh;
  lane_t [3:0] lanes_d;
  lane_t [3:0] lanes_q;

  always_comb begin
    case (format_code_i)
      FmtU8x4: begin
        comps = 3'd4; width = 3'd1;
      end
      FmtU16x2, FmtHalfx2: begin
        comps = 3'd2; width = 3'd2;
      end
      FmtU16x4, FmtHalfx4: begin
        comps = 3'd4; width = 3'd2;
      end
      FmtF32x1a, FmtF32x1b: begin
        comps = 3'd1; width = 3'd4;
      end
      FmtF32x2a, FmtF32x2b: begin
        comps = 3'd2; width = 3'd4;
      end
      FmtF32x3: begin
        comps = 3'd3; width = 3'd4;
      end
      default: begin
        comps = 3'd4; width = 3'd4;
      end
    endcase
    span = 6'(comps * width);
    do32 = (endian_mode_i == EndSwap32) || (endian_mode_i == EndHalves && width == 3'd2);
    doh  = (endian_mode_i == EndHalves) && (width != 3'd2);

    for (int i = 0; i < 8; i++) begin
      byt[i]   = data_lo_i[8*i +: 8];
      byt[i+8] = data_hi_i[8*i +: 8];
    end
    for (int i = 0; i < 16; i++) sw[i] = byt[i];

    if (endian_mode_i == EndSwap16) begin
      for (int g = 0; g < 8; g++) begin
        if (6'(2*g + 1) < span) begin
          sw[2*g]   = byt[2*g+1];
          sw[2*g+1] = byt[2*g];
        end
      end
    end else if (do32) begin
      for (int g = 0; g < 4; g++) begin
        if (6'(4*g + 3) < span) begin
          sw[4*g]   = byt[4*g+3];
          sw[4*g+1] = byt[4*g+2];
          sw[4*g+2] = byt[4*g+1];
          sw[4*g+3] = byt[4*g];
        end
      end
    end else if (doh) begin
      for (int g = 0; g < 4; g++) begin
        if (6'(4*g + 3) < span) begin
          sw[4*g]   = byt[4*g+2];
          sw[4*g+1] = byt[4*g+3];
          sw[4*g+2] = byt[4*g];
          sw[4*g+3] = byt[4*g+1];
        end
      end
    end

    for (int k = 0; k < 4; k++) begin
      lanes_d[k].sgn  = twos_comp_i;
      lanes_d[k].nrm  = unit_norm_i;
      lanes_d[k].wide = 1'b0;
      lanes_d[k].kind = LaneRaw;
      lanes_d[k].raw  = (k == 3) ? OneBits : 32'h0;
      if (3'(k) < comps) begin
        case (format_code_i)
          FmtU8x4: begin
            lanes_d[k].kind = LaneInt;
            lanes_d[k].raw  = {24'h0, sw[k]};
          end
          FmtU16x2, FmtU16x4: begin
            lanes_d[k].kind = LaneInt;
            lanes_d[k].wide = 1'b1;
            lanes_d[k].raw  = {16'h0, sw[2*k+1], sw[2*k]};
          end
          FmtHalfx2, FmtHalfx4: begin
            lanes_d[k].kind = LaneHalf;
            lanes_d[k].raw  = {16'h0, sw[2*k+1], sw[2*k]};
          end
          default: begin
            lanes_d[k].raw = {sw[4*k+3], sw[4*k+2], sw[4*k+1], sw[4*k]};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lanes_q <= lanes_d;
  end

  assign lanes_o = lanes_q;

endmodule

FILE: hw/rtl/vad_conv.sv
`timescale 1ns / 1ps
module vad_conv import vad_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  lane_t       lane_i,
  output logic [31:0] res_o
);

  function automatic logic [4:0] blen(input logic [15:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 16; i++) if (v[i]) r = 5'(i + 1);
    return r;
  endfunction

  logic [15:0] sx;
  logic [15:0] mag;
  logic        neg;
  logic [4:0]  ln;
  logic [4:0]  kk;
  logic [15:0] dd;
  logic [63:0] fp;
  logic [63:0] fs;
  logic [4:0]  sh;
  logic [15:0] msh;
  logic [4:0]  lm;
  logic [10:0] hm;
  logic [31:0] hres;
  logic [31:0] ires;

  logic [31:0] res_d, res_q;
  logic        rnd_d, rnd_q;
  logic        neg_q;
  logic [7:0]  exp_d, exp_q;
  logic [23:0] fr_q;
  logic [31:0] out_d, out_q;

  always_comb begin
    sx = lane_i.wide ? lane_i.raw[15:0] :
         (lane_i.sgn ? {{8{lane_i.raw[7]}}, lane_i.raw[7:0]} : {8'h0, lane_i.raw[7:0]});
    neg = lane_i.sgn & sx[15];
    mag = neg ? 16'(~sx + 16'd1) : sx;
    ln  = blen(mag);
    kk  = lane_i.wide ? (lane_i.sgn ? 5'd15 : 5'd16) : (lane_i.sgn ? 5'd7 : 5'd8);
    dd  = 16'((17'd1 << kk) - 17'd1);

    case ({lane_i.wide, lane_i.sgn})
      2'b00:   for (int i = 0; i < 64; i++) fp[63-i] = mag[7 - (i % 8)];
      2'b01:   for (int i = 0; i < 64; i++) fp[63-i] = mag[6 - (i % 7)];
      2'b10:   for (int i = 0; i < 64; i++) fp[63-i] = mag[15 - (i % 16)];
      default: for (int i = 0; i < 64; i++) fp[63-i] = mag[14 - (i % 15)];
    endcase
    sh    = 5'(kk - ln);
    fs    = fp << sh;
    exp_d = 8'(8'd126 - {3'b0, sh});

    msh  = 16'(mag << (5'd16 - ln));
    ires = (mag == 16'h0) ? 32'h0 : {neg, 8'(8'd126 + {3'b0, ln}), msh[14:0], 8'h0};

    lm = blen({6'h0, lane_i.raw[9:0]});
    hm = 11'({1'b0, lane_i.raw[9:0]} << (5'd11 - lm));
    if (lane_i.raw[14:10] == 5'h0) begin
      if (lane_i.raw[9:0] == 10'h0) hres = {lane_i.raw[15], 31'h0};
      else hres = {lane_i.raw[15], 8'(8'd102 + {3'b0, lm}), hm[9:0], 13'h0};
    end else if (lane_i.raw[14:10] == 5'h1F) begin
      hres = {lane_i.raw[15], 8'hFF, lane_i.raw[9:0], 13'h0};
    end else begin
      hres = {lane_i.raw[15], 8'({3'b0, lane_i.raw[14:10]} + 8'd112), lane_i.raw[9:0], 13'h0};
    end

    rnd_d = 1'b0;
    case (lane_i.kind)
      LaneHalf: res_d = hres;
      LaneInt: begin
        if (!lane_i.nrm) res_d = ires;
        else if (mag == 16'h0) res_d = 32'h0;
        else if (mag >= dd) res_d = {neg, OneBits[30:0]};
        else begin
          res_d = ires;
          rnd_d = 1'b1;
        end
      end
      default: res_d = lane_i.raw;
    endcase

    out_d = rnd_q ? {neg_q, 31'({exp_q, fr_q[23:1]} + 31'(fr_q[0]))} : res_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      rnd_q <= rnd_d;
      neg_q <= neg;
      exp_q <= exp_d;
      fr_q  <= fs[62:39];
      out_q <= out_d;
    end
  end

  assign res_o = out_q;

endmodule

FILE: hw/rtl/vertex_attribute_decode_core.sv
`timescale 1ns / 1ps
// Decodes one vertex attribute word (16 raw bytes, format, endian mode, signed and
// normalised flags) into four IEEE single components, missing ones reading 0,0,0,1.
// Three register stages: byte swap and lane split, conversion, rounding into the
// output register. One word per clock unless the output stalls, and a stall at the
// output holds the whole pipe.
module vertex_attribute_decode_core import vad_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  vad_in_if.sink    in_i,
  vad_out_if.source out_o
);

  logic        adv;
  logic        va_q, vb_q, vc_q;
  lane_t [3:0] lanes;
  logic [31:0] res [4];

  assign adv      = ~vc_q | out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  vad_unpack u_unpack (
    .clk_i          (clk_i),
    .en_i           (adv),
    .data_lo_i      (in_i.data_lo),
    .data_hi_i      (in_i.data_hi),
    .format_code_i  (in_i.format_code),
    .endian_mode_i  (in_i.endian_mode),
    .twos_comp_i    (in_i.twos_comp),
    .unit_norm_i    (in_i.unit_norm),
    .lanes_o        (lanes)
  );

  for (genvar k = 0; k < 4; k++) begin : g_lane
    vad_conv u_conv (
      .clk_i (clk_i),
      .en_i  (adv),
      .lane_i(lanes[k]),
      .res_o (res[k])
    );
  end

  assign out_o.valid  = vc_q;
  assign out_o.comp_x = res[0];
  assign out_o.comp_y = res[1];
  assign out_o.comp_z = res[2];
  assign out_o.comp_w = res[3];

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> va_q) else $error("accepted word not in stage one");
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !adv) |=> vb_q) else $error("stage two lost a word during stall");
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(vb_q)) else $error("output valid without stage two word");
`endif

endmodule
